>>> src/nps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, result codes and controller interface types of the priority scheduler.
package nps_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned ID_BITS_DEF   = 8;
  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned PRIO_W        = 8;
  localparam int unsigned STATUS_W      = 2;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_BURST = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;        // capture the input word
    logic add_exec;     // store a job or reject it
    logic rd_run;       // read the entry of the running job
    logic load_run;     // copy that entry into the selection registers
    logic scan_start;   // clear the selection and read slot zero
    logic scan_step;    // judge one slot and read the next
    logic run_exec;     // run one unit of the selected job
    logic idle_result;  // report a tick with nothing to run
  } nps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic running;
    logic scan_last;
    logic found;
  } nps_sts_t;

endpackage

>>> src/nps_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the priority scheduler.
module nps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              kind_i,
  input  nps_pkg::nps_sts_t sts_i,
  output nps_pkg::nps_cmd_t cmd_o,
  output logic              busy_o
);
  import nps_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_RLOAD = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_PICK  = 3'd4;
  localparam logic [2:0] ST_RUN   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          if (kind_i == KIND_ADD) begin
            state_d = ST_ADD;
          end else if (sts_i.running) begin
            cmd_o.rd_run = 1'b1;
            state_d      = ST_RLOAD;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_ADD: begin
        cmd_o.add_exec = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_RLOAD: begin
        cmd_o.load_run = 1'b1;
        state_d        = ST_RUN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (sts_i.found) begin
          state_d = ST_RUN;
        end else begin
          cmd_o.idle_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_RUN: begin
        cmd_o.run_exec = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> src/nps_datapath.sv
`timescale 1ns / 1ps
// Job table, slot scan and result registers of the priority scheduler.
module nps_datapath #(
  parameter int unsigned SLOTS     = nps_pkg::SLOTS_DEF,
  parameter int unsigned ID_BITS   = nps_pkg::ID_BITS_DEF,
  parameter int unsigned TIME_BITS = nps_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nps_pkg::nps_cmd_t             cmd_i,
  output nps_pkg::nps_sts_t             sts_o,
  input  logic [ID_BITS-1:0]            job_id_i,
  input  logic [TIME_BITS-1:0]          arrival_i,
  input  logic [TIME_BITS-1:0]          burst_i,
  input  logic [nps_pkg::PRIO_W-1:0]    prio_i,
  input  logic [TIME_BITS-1:0]          now_i,
  output logic                          valid_o,
  output logic [nps_pkg::STATUS_W-1:0]  status_o,
  output logic                          cpu_busy_o,
  output logic [ID_BITS-1:0]            running_id_o,
  output logic                          job_done_o,
  output logic [TIME_BITS-1:0]          waiting_time_o
);
  import nps_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  // Job table, one read and one write port.
  logic [ID_BITS-1:0]   mem_id    [SLOTS];
  logic [TIME_BITS-1:0] mem_arr   [SLOTS];
  logic [TIME_BITS-1:0] mem_burst [SLOTS];
  logic [TIME_BITS-1:0] mem_rem   [SLOTS];
  logic [PRIO_W-1:0]    mem_prio  [SLOTS];

  logic [ID_BITS-1:0]   rd_id_q;
  logic [TIME_BITS-1:0] rd_arr_q, rd_burst_q, rd_rem_q;
  logic [PRIO_W-1:0]    rd_prio_q;
  logic [IDX_W-1:0]     rd_slot_q;

  logic [ID_BITS-1:0]   best_id_q;
  logic [TIME_BITS-1:0] best_arr_q, best_burst_q, best_rem_q;
  logic [PRIO_W-1:0]    best_prio_q;
  logic [IDX_W-1:0]     best_slot_q;

  logic [ID_BITS-1:0]   job_id_q;
  logic [TIME_BITS-1:0] arrival_q, burst_q, now_q;
  logic [PRIO_W-1:0]    prio_q;

  logic [SLOTS-1:0] fin_q;
  logic [CNT_W-1:0] used_q;
  logic [CNT_W-1:0] cnt_q;
  logic             found_q;
  logic             running_q;
  logic [IDX_W-1:0] running_slot_q;

  logic                 valid_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 cpu_busy_q;
  logic [ID_BITS-1:0]   running_id_q;
  logic                 job_done_q;
  logic [TIME_BITS-1:0] waiting_time_q;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 add_ok;
  logic                 cand;
  logic [TIME_BITS-1:0] new_rem;
  logic                 run_done;
  logic [TIME_BITS:0]   finish, spent, diff;
  logic [TIME_BITS-1:0] wait_sat;

  // Read port: the running job, or the next slot of a scan.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q[IDX_W-1:0];
    if (cmd_i.rd_run) begin
      rd_en   = 1'b1;
      rd_addr = running_slot_q;
    end else if (cmd_i.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd_i.scan_step && (cnt_q < SLOTS_CNT)) begin
      rd_en = 1'b1;
    end
  end

  assign add_ok = (burst_q != '0) && (used_q != SLOTS_CNT);

  // A slot is a candidate if it holds an unfinished job that has arrived and
  // beats the best one seen so far; ties keep the earlier slot.
  assign cand = (CNT_W'(rd_slot_q) < used_q) && !fin_q[rd_slot_q] &&
                (rd_arr_q <= now_q) && (!found_q || (rd_prio_q < best_prio_q));

  assign new_rem  = (best_rem_q != '0) ? best_rem_q - 1'b1 : best_rem_q;
  assign run_done = (new_rem == '0);
  assign finish   = {1'b0, now_q} + 1'b1;
  assign spent    = {1'b0, best_arr_q} + {1'b0, best_burst_q};
  assign diff     = (finish > spent) ? finish - spent : '0;
  assign wait_sat = diff[TIME_BITS] ? '1 : diff[TIME_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_exec && add_ok) begin
      mem_id[used_q[IDX_W-1:0]]    <= job_id_q;
      mem_arr[used_q[IDX_W-1:0]]   <= arrival_q;
      mem_burst[used_q[IDX_W-1:0]] <= burst_q;
      mem_rem[used_q[IDX_W-1:0]]   <= burst_q;
      mem_prio[used_q[IDX_W-1:0]]  <= prio_q;
    end else if (cmd_i.run_exec) begin
      mem_rem[best_slot_q] <= new_rem;
    end
    if (rd_en) begin
      rd_id_q    <= mem_id[rd_addr];
      rd_arr_q   <= mem_arr[rd_addr];
      rd_burst_q <= mem_burst[rd_addr];
      rd_rem_q   <= mem_rem[rd_addr];
      rd_prio_q  <= mem_prio[rd_addr];
      rd_slot_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      job_id_q  <= job_id_i;
      arrival_q <= arrival_i;
      burst_q   <= burst_i;
      prio_q    <= prio_i;
      now_q     <= now_i;
    end
    if (cmd_i.load_run || (cmd_i.scan_step && cand)) begin
      best_id_q    <= rd_id_q;
      best_arr_q   <= rd_arr_q;
      best_burst_q <= rd_burst_q;
      best_rem_q   <= rd_rem_q;
      best_prio_q  <= rd_prio_q;
      best_slot_q  <= rd_slot_q;
    end
    status_q       <= STATUS_OK;
    cpu_busy_q     <= 1'b0;
    running_id_q   <= '0;
    job_done_q     <= 1'b0;
    waiting_time_q <= '0;
    if (cmd_i.add_exec) begin
      if (burst_q == '0) begin
        status_q <= STATUS_ZERO_BURST;
      end else if (used_q == SLOTS_CNT) begin
        status_q <= STATUS_FULL;
      end
    end
    if (cmd_i.run_exec) begin
      cpu_busy_q   <= 1'b1;
      running_id_q <= best_id_q;
      if (run_done) begin
        job_done_q     <= 1'b1;
        waiting_time_q <= wait_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q          <= '0;
      used_q         <= '0;
      cnt_q          <= '0;
      found_q        <= 1'b0;
      running_q      <= 1'b0;
      running_slot_q <= '0;
      valid_q        <= 1'b0;
    end else begin
      valid_q <= cmd_i.add_exec || cmd_i.run_exec || cmd_i.idle_result;
      if (cmd_i.add_exec && add_ok) begin
        fin_q[used_q[IDX_W-1:0]] <= 1'b0;
        used_q                   <= used_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        cnt_q   <= CNT_W'(1);
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cnt_q <= cnt_q + 1'b1;
        if (cand) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.run_exec) begin
        running_slot_q <= best_slot_q;
        running_q      <= !run_done;
        if (run_done) begin
          fin_q[best_slot_q] <= 1'b1;
        end
      end else if (cmd_i.idle_result) begin
        running_q <= 1'b0;
      end
    end
  end

  assign sts_o.running   = running_q;
  assign sts_o.scan_last = (cnt_q == SLOTS_CNT);
  assign sts_o.found     = found_q;

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign cpu_busy_o     = cpu_busy_q;
  assign running_id_o   = running_id_q;
  assign job_done_o     = job_done_q;
  assign waiting_time_o = waiting_time_q;

endmodule

>>> src/nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// Nonpreemptive priority scheduler: job table with add and tick commands.
//
// A command word is taken at a rising edge where start_i is high and busy_o
// is low. kind_i selects an add (job_id_i, arrival_i, burst_i, prio_i) or a
// scheduler tick (now_i). Every command gives exactly one result word, shown
// on the result ports for one cycle with valid_o high. The receiver cannot
// stall; a result is simply taken at the edge that ends its cycle.
// Steps from the accepting edge to the cycle with valid_o high:
//   add: the job is stored or rejected.
//   tick while a job is running: one table read, then the update.
//   tick with no running job: the single table read port visits one slot per
//   cycle to find the most urgent ready job, then the pick and, when a ready
//   job is found, the update.
// busy_o drops in the cycle that carries the result, so the next command is
// taken at the edge that ends it.
// Reset clears the valid, finished and occupancy state and the running job;
// the table entries themselves hold nothing meaningful until written.
module nonpreemptive_priority_scheduler #(
  parameter int unsigned SLOTS     = nps_pkg::SLOTS_DEF,
  parameter int unsigned ID_BITS   = nps_pkg::ID_BITS_DEF,
  parameter int unsigned TIME_BITS = nps_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [ID_BITS-1:0]            job_id_i,
  input  logic [TIME_BITS-1:0]          arrival_i,
  input  logic [TIME_BITS-1:0]          burst_i,
  input  logic [nps_pkg::PRIO_W-1:0]    prio_i,
  input  logic [TIME_BITS-1:0]          now_i,
  output logic                          valid_o,
  output logic [nps_pkg::STATUS_W-1:0]  status_o,
  output logic                          cpu_busy_o,
  output logic [ID_BITS-1:0]            running_id_o,
  output logic                          job_done_o,
  output logic [TIME_BITS-1:0]          waiting_time_o
);
  import nps_pkg::*;

  nps_cmd_t cmd;
  nps_sts_t sts;

  nps_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  nps_datapath #(
    .SLOTS     (SLOTS),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .job_id_i       (job_id_i),
    .arrival_i      (arrival_i),
    .burst_i        (burst_i),
    .prio_i         (prio_i),
    .now_i          (now_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .cpu_busy_o     (cpu_busy_o),
    .running_id_o   (running_id_o),
    .job_done_o     (job_done_o),
    .waiting_time_o (waiting_time_o)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nonpreemptive priority scheduler.
package sched_tb_pkg;
  import nps_pkg::*;

  localparam int unsigned N_SLOTS = SLOTS_DEF;
  localparam int unsigned ID_W    = ID_BITS_DEF;
  localparam int unsigned T_W     = TIME_BITS_DEF;

  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     job_id;
    logic [T_W-1:0]      arrival;
    logic [T_W-1:0]      burst;
    logic [PRIO_W-1:0]   prio;
    logic [T_W-1:0]      now;
  } sched_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                cpu_busy;
    logic [ID_W-1:0]     running_id;
    logic                job_done;
    logic [T_W-1:0]      waiting_time;
  } sched_result_t;

  class sched_scoreboard;
    bit                occupied  [N_SLOTS];
    bit                completed [N_SLOTS];
    bit [ID_W-1:0]     ids       [N_SLOTS];
    bit [T_W-1:0]      arrivals  [N_SLOTS];
    bit [T_W-1:0]      lengths   [N_SLOTS];
    bit [T_W-1:0]      left      [N_SLOTS];
    bit [PRIO_W-1:0]   prios     [N_SLOTS];
    int unsigned       fill;
    bit                active;
    int unsigned       active_slot;
    sched_result_t     expected_q[$];
    int unsigned       errors;

    function bit table_full();
      return fill >= N_SLOTS;
    endfunction

    // One unit of work for the job in slot s; reports its wait when it ends.
    function sched_result_t run_unit(int unsigned s, logic [T_W-1:0] t);
      sched_result_t r;
      logic [T_W+1:0] finish;
      logic [T_W+1:0] spent;
      logic [T_W+1:0] late;
      r = '0;
      r.cpu_busy = 1'b1;
      r.running_id = ids[s];
      if (left[s] != 0) left[s]--;
      if (left[s] == 0) begin
        finish = {2'b00, t} + (T_W+2)'(1);
        spent = {2'b00, arrivals[s]} + {2'b00, lengths[s]};
        late = (finish > spent) ? finish - spent : '0;
        r.waiting_time = (late > {2'b00, {T_W{1'b1}}}) ? {T_W{1'b1}} : late[T_W-1:0];
        r.job_done = 1'b1;
        completed[s] = 1'b1;
        active = 1'b0;
      end
      return r;
    endfunction

    function void note_word(sched_cmd_t w);
      sched_result_t r;
      bit found;
      int unsigned best;
      r = '0;
      found = 1'b0;
      best = 0;
      if (w.kind == KIND_ADD) begin
        if (w.burst == 0) begin
          r.status = STATUS_ZERO_BURST;
        end else if (fill >= N_SLOTS) begin
          r.status = STATUS_FULL;
        end else begin
          r.status = STATUS_OK;
          occupied[fill] = 1'b1;
          completed[fill] = 1'b0;
          ids[fill] = w.job_id;
          arrivals[fill] = w.arrival;
          lengths[fill] = w.burst;
          left[fill] = w.burst;
          prios[fill] = w.prio;
          fill++;
        end
      end else if (active && occupied[active_slot] && !completed[active_slot]) begin
        r = run_unit(active_slot, w.now);
      end else begin
        active = 1'b0;
        // Strict less-than keeps the lowest slot on equal priority.
        for (int unsigned i = 0; i < N_SLOTS; i++) begin
          if (occupied[i] && !completed[i] && arrivals[i] <= w.now &&
              (!found || prios[i] < prios[best])) begin
            found = 1'b1;
            best = i;
          end
        end
        if (found) begin
          active = 1'b1;
          active_slot = best;
          r = run_unit(best, w.now);
        end
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) report($sformatf("%s is %0d, should be %0d", name, got, want));
    endtask

    task check_word(sched_result_t got);
      sched_result_t want;
      if (expected_q.size() == 0) begin
        report("result word with none outstanding");
        return;
      end
      want = expected_q.pop_front();
      check_field("status", 64'(got.status), 64'(want.status));
      check_field("cpu_busy", 64'(got.cpu_busy), 64'(want.cpu_busy));
      check_field("running_id", 64'(got.running_id), 64'(want.running_id));
      check_field("job_done", 64'(got.job_done), 64'(want.job_done));
      check_field("waiting_time", 64'(got.waiting_time), 64'(want.waiting_time));
    endtask
  endclass
endpackage

module testbench;
  import nps_pkg::*;
  import sched_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 930;
  localparam int unsigned DRAIN_CYCLES = 2 * N_SLOTS + 8;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start_i    = 1'b0;
  logic                kind_i     = 1'b0;
  logic [ID_W-1:0]     job_id_i   = '0;
  logic [T_W-1:0]      arrival_i  = '0;
  logic [T_W-1:0]      burst_i    = '0;
  logic [PRIO_W-1:0]   prio_i     = '0;
  logic [T_W-1:0]      now_i      = '0;
  logic                busy_o;
  logic                valid_o;
  logic [STATUS_W-1:0] status_o;
  logic                cpu_busy_o;
  logic [ID_W-1:0]     running_id_o;
  logic                job_done_o;
  logic [T_W-1:0]      waiting_time_o;

  sched_scoreboard sb = new;
  int unsigned     idle_pct = 8;
  int unsigned     cycle_count = 0;
  logic [T_W-1:0]  clock_now = '0;

  nonpreemptive_priority_scheduler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .job_id_i       (job_id_i),
    .arrival_i      (arrival_i),
    .burst_i        (burst_i),
    .prio_i         (prio_i),
    .now_i          (now_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .cpu_busy_o     (cpu_busy_o),
    .running_id_o   (running_id_o),
    .job_done_o     (job_done_o),
    .waiting_time_o (waiting_time_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_word({status_o, cpu_busy_o, running_id_o, job_done_o, waiting_time_o});
  end

  task automatic send_word(sched_cmd_t w);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start_i   <= 1'b1;
    kind_i    <= w.kind;
    job_id_i  <= w.job_id;
    arrival_i <= w.arrival;
    burst_i   <= w.burst;
    prio_i    <= w.prio;
    now_i     <= w.now;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_word(w);
  endtask

  task automatic add_job(logic [ID_W-1:0] id, logic [T_W-1:0] arr, logic [T_W-1:0] len,
                         logic [PRIO_W-1:0] pr);
    sched_cmd_t w;
    w.kind = KIND_ADD;
    w.job_id = id;
    w.arrival = arr;
    w.burst = len;
    w.prio = pr;
    w.now = T_W'($urandom);
    send_word(w);
  endtask

  // Job fields are ignored on a tick, so they carry noise.
  task automatic tick(logic [T_W-1:0] t);
    sched_cmd_t w;
    w.kind = KIND_TICK;
    w.job_id = ID_W'($urandom);
    w.arrival = T_W'($urandom);
    w.burst = T_W'($urandom);
    w.prio = PRIO_W'($urandom);
    w.now = t;
    send_word(w);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Time mostly creeps forward so jobs arrive and run in order; now and then it jumps.
  task automatic random_word();
    logic [T_W-1:0] arr;
    logic [T_W-1:0] len;
    logic [PRIO_W-1:0] pr;
    if ($urandom_range(0, 99) < (sb.table_full() ? 6 : 4)) begin
      if ($urandom_range(0, 7) == 0) len = '0;
      else if (sb.table_full()) len = T_W'($urandom);
      else if ($urandom_range(0, 5) == 0) len = T_W'($urandom_range(17, 120));
      else len = T_W'($urandom_range(1, 16));
      case ($urandom_range(0, 9)) inside
        0:       arr = T_W'($urandom);
        [1:3]:   arr = T_W'(clock_now + $urandom_range(1, 30));
        default: arr = T_W'(clock_now - $urandom_range(0, 10));
      endcase
      pr = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom);
      add_job(ID_W'($urandom), arr, len, pr);
    end else begin
      if ($urandom_range(0, 24) == 0) clock_now = T_W'($urandom);
      else clock_now = T_W'(clock_now + $urandom_range(0, 2));
      tick(clock_now);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    tick(16'd0);                              // nothing stored yet
    add_job(8'hFF, 16'hFFFF, 16'd0, 8'hFF);   // zero burst is refused
    add_job(8'hFF, 16'hFFFF, 16'd2, 8'h00);
    tick(16'hFFFE);                           // stored job has not arrived
    add_job(8'h00, 16'h0000, 16'd1, 8'hFF);
    tick(16'hFFFE);                           // only the low-urgency job is ready
    tick(16'hFFFF);
    add_job(8'h07, 16'h0000, 16'd3, 8'h00);
    tick(16'h0000);                           // running job keeps the CPU, wait clamps to zero
    add_job(8'h09, 16'h0000, 16'd1, 8'h00);
    repeat (4) tick(16'd5);                   // equal priority goes to the lower slot
    tick(16'd5);                              // everything finished
    drain_results();

    clock_now = 16'd6;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 56 : 0;
      repeat (RANDOM_ITEMS / 3) random_word();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> nonpreemptive_priority_scheduler.f
src/nps_pkg.sv
src/nps_ctrl.sv
src/nps_datapath.sv
src/nonpreemptive_priority_scheduler.sv
bench/testbench.sv
